>>> src/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and fixed widths of the shelf rectangle packer.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int IDX_W   = 6;
    localparam int DATA_W  = 16;
    localparam int AREA_W  = 38;
    localparam int ROOT_W  = 20;
    localparam int STRIP_W = ROOT_W + 1;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] h;
        logic [DATA_W-1:0] w;
    } t_rect;

    typedef struct packed {
        logic [DATA_W-1:0] h;
        logic [DATA_W-1:0] w;
        logic [DATA_W-1:0] bottom;
        logic [DATA_W-1:0] left;
    } t_space;

endpackage

>>> src/spr_strip.sv
// ----------------------------------------------------------------------------
// spr_strip
// Smallest w with 19*w*w >= 20*area; each root bit takes a square phase and a compare phase.
// ----------------------------------------------------------------------------
module spr_strip (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [spr_pkg::AREA_W-1:0]   i_area,
    output logic                         o_done,
    output logic [spr_pkg::STRIP_W-1:0]  o_width
);

    localparam int T_W  = spr_pkg::AREA_W + 5;
    localparam int SQ_W = 2 * spr_pkg::ROOT_W;
    localparam int BI_W = $clog2(spr_pkg::ROOT_W);

    logic                        r_busy;
    logic                        r_phase;
    logic [BI_W-1:0]             r_bit;
    logic [spr_pkg::ROOT_W-1:0]  r_v;
    logic [T_W-1:0]              r_target;
    logic [SQ_W-1:0]             r_sq;
    logic                        r_done;
    logic [spr_pkg::STRIP_W-1:0] r_width;

    logic [spr_pkg::ROOT_W-1:0]  cand;
    logic [T_W+1:0]              lhs;

    assign cand = r_v | (spr_pkg::ROOT_W'(1) << r_bit);
    assign lhs  = (T_W+2)'(r_sq) * (T_W+2)'(19);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_phase  <= 1'b0;
                r_bit    <= BI_W'(spr_pkg::ROOT_W - 1);
                r_v      <= '0;
                r_target <= T_W'(i_area) * T_W'(20);
            end else if (r_busy) begin
                if (!r_phase) begin
                    r_sq    <= SQ_W'(cand) * SQ_W'(cand);
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    if (lhs < (T_W+2)'(r_target)) begin
                        r_v <= cand;
                    end
                    if (r_bit == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        if (r_target == '0) begin
                            r_width <= '0;
                        end else if (lhs < (T_W+2)'(r_target)) begin
                            r_width <= spr_pkg::STRIP_W'(cand) + 1'b1;
                        end else begin
                            r_width <= spr_pkg::STRIP_W'(r_v) + 1'b1;
                        end
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_width = r_width;

endmodule

>>> src/shelf_rectangle_packer.sv
// ----------------------------------------------------------------------------
// shelf_rectangle_packer
// Loads rectangles, keeps them height sorted, then packs them into a strip
// with guillotine splitting of free spaces.
// ----------------------------------------------------------------------------
// Each loaded word is inserted into a height-sorted rectangle memory: after
// its area is accumulated, each stored rectangle that is taller is read and
// moved up one place. The last word starts packing: a strip width search
// (a square and a compare phase per root bit), then per rectangle a read of
// it, a check of each free space from the newest down, the later spaces moved
// down on an exact fit, the new space written on a split, and the result word
// handed to the output register. Input is not taken while a run is packing.
module shelf_rectangle_packer #(
    parameter int MAX_RECTS  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // rect_width, rect_height
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // rect_index, pos_left, pos_bottom,
                                        // total_width, total_height, zero pad
    output logic        m_axis_tuser,   // placed
    output logic        m_axis_tlast
);

    localparam int RI = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int SD = MAX_RECTS + 1;
    localparam int SI = $clog2(SD);
    localparam int SC = $clog2(SD + 1);
    localparam int DW = spr_pkg::DATA_W;
    localparam logic [DW-1:0] COORD_MAX = DW'((17'd1 << COORD_BITS) - 17'd1);

    typedef enum logic [12:0] {
        S_LOAD   = 13'b0000000000001,
        S_ACC    = 13'b0000000000010,
        S_INS    = 13'b0000000000100,
        S_INSCMP = 13'b0000000001000,
        S_STRIP  = 13'b0000000010000,
        S_SWAIT  = 13'b0000000100000,
        S_PKRD   = 13'b0000001000000,
        S_PKLAT  = 13'b0000010000000,
        S_SCRD   = 13'b0000100000000,
        S_SCCHK  = 13'b0001000000000,
        S_MV     = 13'b0010000000000,
        S_SPLIT  = 13'b0100000000000,
        S_EMIT   = 13'b1000000000000
    } t_state;

    t_state r_state;

    spr_pkg::t_rect  rmem [MAX_RECTS];
    spr_pkg::t_space smem [SD];
    spr_pkg::t_rect  r_rm_rd;
    spr_pkg::t_space r_sm_rd;

    logic                 rm_we;
    logic [RI-1:0]        rm_waddr, rm_raddr;
    spr_pkg::t_rect       rm_wdata;
    logic                 sm_we;
    logic [SI-1:0]        sm_waddr, sm_raddr;
    spr_pkg::t_space      sm_wdata;

    logic [CW-1:0]               r_cnt;
    logic [spr_pkg::AREA_W-1:0]  r_area;
    logic [DW-1:0]               r_widest;
    logic [2*DW-1:0]             r_prod;
    spr_pkg::t_rect              r_key;
    logic [RI-1:0]               r_j;
    logic                        r_last;
    logic [RI-1:0]               r_i;
    spr_pkg::t_rect              r_rect;
    logic [SC-1:0]               r_sc;
    logic [SI-1:0]               r_k;
    logic [SI-1:0]               r_m;
    logic [DW:0]                 r_ext_w, r_ext_h;
    logic [DW-1:0]               r_left, r_bottom;
    logic                        r_placed;
    spr_pkg::t_space             r_new;

    logic                        r_ov;
    logic [71:0]                 r_odata;
    logic                        r_ouser, r_olast;

    logic                        st_start, st_done;
    logic [spr_pkg::STRIP_W-1:0] st_width;
    logic [spr_pkg::STRIP_W-1:0] strip_w;
    logic [DW-1:0]               in_w, in_h;
    logic                        fit;
    logic [DW:0]                 end_w, end_h;

    assign in_w = s_axis_tdata[15:0];
    assign in_h = s_axis_tdata[31:16];
    assign s_axis_tready = (r_state == S_LOAD);
    assign st_start = (r_state == S_STRIP);

    spr_strip u_strip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (st_start),
        .i_area  (r_area),
        .o_done  (st_done),
        .o_width (st_width)
    );

    always_comb begin
        strip_w = st_width;
        if (strip_w < spr_pkg::STRIP_W'(r_widest)) strip_w = spr_pkg::STRIP_W'(r_widest);
        if (strip_w > spr_pkg::STRIP_W'(COORD_MAX)) strip_w = spr_pkg::STRIP_W'(COORD_MAX);
    end

    assign fit   = (r_rect.w <= r_sm_rd.w) && (r_rect.h <= r_sm_rd.h);
    assign end_w = {1'b0, r_sm_rd.left} + {1'b0, r_rect.w};
    assign end_h = {1'b0, r_sm_rd.bottom} + {1'b0, r_rect.h};

    // memory port control
    always_comb begin
        rm_we    = 1'b0;
        rm_waddr = r_j;
        rm_wdata = r_key;
        rm_raddr = r_j - 1'b1;
        sm_we    = 1'b0;
        sm_waddr = r_k;
        sm_wdata = r_sm_rd;
        sm_raddr = r_k;
        case (r_state)
            S_INS: begin
                if (r_j == '0) rm_we = 1'b1;
            end
            S_INSCMP: begin
                rm_we = 1'b1;
                if (r_rm_rd.h > r_key.h) rm_wdata = r_rm_rd;
            end
            S_PKRD: begin
                rm_raddr = r_i;
            end
            S_SWAIT: begin
                sm_we    = st_done;
                sm_waddr = '0;
                sm_wdata = '{h: COORD_MAX, w: DW'(strip_w), bottom: '0, left: '0};
            end
            S_SCCHK: begin
                if (fit) begin
                    if (r_rect.w == r_sm_rd.w && r_rect.h == r_sm_rd.h) begin
                        sm_raddr = r_k + 1'b1;
                    end else if (r_rect.h == r_sm_rd.h) begin
                        sm_we    = 1'b1;
                        sm_wdata = '{h: r_sm_rd.h, w: r_sm_rd.w - r_rect.w,
                                     bottom: r_sm_rd.bottom, left: end_w[DW-1:0]};
                    end else begin
                        sm_we    = 1'b1;
                        sm_wdata = '{h: r_sm_rd.h - r_rect.h, w: r_sm_rd.w,
                                     bottom: end_h[DW-1:0], left: r_sm_rd.left};
                    end
                end
            end
            S_MV: begin
                sm_raddr = r_m + SI'(2);
                sm_waddr = r_m;
                sm_we    = (SC'(r_m) + 1'b1 < r_sc);
            end
            S_SPLIT: begin
                sm_waddr = r_sc[SI-1:0];
                sm_wdata = r_new;
                sm_we    = (r_sc < SC'(SD));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rm_we) rmem[rm_waddr] <= rm_wdata;
        r_rm_rd <= rmem[rm_raddr];
        if (sm_we) smem[sm_waddr] <= sm_wdata;
        r_sm_rd <= smem[sm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_area   <= '0;
            r_widest <= '0;
            r_sc     <= '0;
            r_ext_w  <= '0;
            r_ext_h  <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (m_axis_tready && r_state != S_EMIT) r_ov <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (s_axis_tvalid) begin
                        r_key    <= '{idx: spr_pkg::IDX_W'(r_cnt), h: in_h, w: in_w};
                        r_prod   <= (2*DW)'(in_w) * (2*DW)'(in_h);
                        r_j      <= r_cnt[RI-1:0];
                        r_last   <= s_axis_tlast || (r_cnt + 1'b1 == CW'(MAX_RECTS));
                        r_cnt    <= r_cnt + 1'b1;
                        if (in_w > r_widest) begin
                            r_widest <= (in_w > COORD_MAX) ? COORD_MAX : in_w;
                        end else if (r_widest > COORD_MAX) begin
                            r_widest <= COORD_MAX;
                        end
                        r_state  <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_area  <= r_area + spr_pkg::AREA_W'(r_prod);
                    r_state <= S_INS;
                end
                S_INS: begin
                    if (r_j == '0) begin
                        r_state <= r_last ? S_STRIP : S_LOAD;
                    end else begin
                        r_state <= S_INSCMP;
                    end
                end
                S_INSCMP: begin
                    if (r_rm_rd.h > r_key.h) begin
                        r_j     <= r_j - 1'b1;
                        r_state <= S_INS;
                    end else begin
                        r_state <= r_last ? S_STRIP : S_LOAD;
                    end
                end
                S_STRIP: begin
                    r_state <= S_SWAIT;
                end
                S_SWAIT: begin
                    if (st_done) begin
                        r_sc    <= SC'(1);
                        r_ext_w <= '0;
                        r_ext_h <= '0;
                        r_i     <= '0;
                        r_state <= S_PKRD;
                    end
                end
                S_PKRD: begin
                    r_state <= S_PKLAT;
                end
                S_PKLAT: begin
                    r_rect   <= r_rm_rd;
                    r_placed <= 1'b0;
                    r_left   <= '0;
                    r_bottom <= '0;
                    if (r_sc == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_k     <= SI'(r_sc - 1'b1);
                        r_state <= S_SCRD;
                    end
                end
                S_SCRD: begin
                    r_state <= S_SCCHK;
                end
                S_SCCHK: begin
                    if (fit) begin
                        r_placed <= 1'b1;
                        r_left   <= r_sm_rd.left;
                        r_bottom <= r_sm_rd.bottom;
                        if (end_w > r_ext_w) r_ext_w <= end_w;
                        if (end_h > r_ext_h) r_ext_h <= end_h;
                        r_new <= '{h: r_rect.h, w: r_sm_rd.w - r_rect.w,
                                   bottom: r_sm_rd.bottom, left: end_w[DW-1:0]};
                        if (r_rect.w == r_sm_rd.w && r_rect.h == r_sm_rd.h) begin
                            r_m     <= r_k;
                            r_state <= S_MV;
                        end else if (r_rect.w == r_sm_rd.w || r_rect.h == r_sm_rd.h) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_SPLIT;
                        end
                    end else if (r_k == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_SCRD;
                    end
                end
                S_MV: begin
                    // read of m+1 issued last cycle lands in r_sm_rd now
                    if (SC'(r_m) + 1'b1 < r_sc) begin
                        r_m <= r_m + 1'b1;
                    end else begin
                        r_sc    <= r_sc - 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_SPLIT: begin
                    if (r_sc < SC'(SD)) r_sc <= r_sc + 1'b1;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_odata <= {2'b00, r_ext_h[DW-1:0], r_ext_w[DW-1:0],
                                    r_bottom, r_left, r_rect.idx};
                        r_ouser <= r_placed;
                        r_olast <= (CW'(r_i) + 1'b1 == r_cnt);
                        if (CW'(r_i) + 1'b1 == r_cnt) begin
                            r_cnt    <= '0;
                            r_area   <= '0;
                            r_widest <= '0;
                            r_sc     <= '0;
                            r_state  <= S_LOAD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_PKRD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives rectangle sets of random and extreme sizes into the packer, predicts
// the placement of each set in software and checks every result word.
// ----------------------------------------------------------------------------

class pack_scoreboard;
    spr_pkg::t_rect   rects[$];
    spr_pkg::t_space  spaces[$];
    logic [37:0] area;
    logic [15:0] widest;
    int      n_held;
    logic [71:0] exp_data[$];
    logic        exp_placed[$];
    logic        exp_last[$];
    int      errors;

    function new();
        n_held = 0;
        area = 0;
        widest = 0;
        errors = 0;
    endfunction

    function logic [15:0] strip_width();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] target;
        lo = 0;
        hi = 64'd1 << 20;
        target = 64'd20 * area;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (64'd19 * mid * mid >= target) hi = mid;
            else lo = mid + 1;
        end
        if (lo < widest) lo = widest;
        if (lo > 65535) lo = 65535;
        return lo[15:0];
    endfunction

    function void pack_set();
        int i;
        int j;
        int k;
        spr_pkg::t_rect  r;
        spr_pkg::t_space s;
        spr_pkg::t_space ns;
        logic [16:0] ext_w;
        logic [16:0] ext_h;
        logic [15:0] left;
        logic [15:0] bottom;
        logic        placed;
        for (i = 1; i < rects.size(); i++) begin
            r = rects[i];
            j = i;
            while (j > 0 && rects[j-1].h > r.h) begin
                rects[j] = rects[j-1];
                j--;
            end
            rects[j] = r;
        end
        ext_w = 0;
        ext_h = 0;
        spaces.delete();
        s.left = 0;
        s.bottom = 0;
        s.w = strip_width();
        s.h = 16'hFFFF;
        spaces.push_back(s);
        for (i = 0; i < rects.size(); i++) begin
            r = rects[i];
            left = 0;
            bottom = 0;
            placed = 0;
            for (k = spaces.size() - 1; k >= 0; k--) begin
                s = spaces[k];
                if (r.w > s.w || r.h > s.h) continue;
                left = s.left;
                bottom = s.bottom;
                placed = 1;
                if (left + r.w > ext_w) ext_w = left + r.w;
                if (bottom + r.h > ext_h) ext_h = bottom + r.h;
                if (r.w == s.w && r.h == s.h) begin
                    spaces.delete(k);
                end else if (r.w == s.w) begin
                    spaces[k].bottom = s.bottom + r.h;
                    spaces[k].h = s.h - r.h;
                end else if (r.h == s.h) begin
                    spaces[k].left = s.left + r.w;
                    spaces[k].w = s.w - r.w;
                end else begin
                    if (spaces.size() < 65) begin
                        ns.left = s.left + r.w;
                        ns.bottom = s.bottom;
                        ns.w = s.w - r.w;
                        ns.h = r.h;
                        spaces.push_back(ns);
                    end
                    spaces[k].bottom = s.bottom + r.h;
                    spaces[k].h = s.h - r.h;
                end
                break;
            end
            exp_data.push_back({2'b00, ext_h[15:0], ext_w[15:0], bottom, left, r.idx});
            exp_placed.push_back(placed);
            exp_last.push_back(i == rects.size() - 1);
        end
        rects.delete();
        n_held = 0;
        area = 0;
        widest = 0;
    endfunction

    function void note_rect(logic [15:0] w, logic [15:0] h, logic last);
        spr_pkg::t_rect r;
        r.w = w;
        r.h = h;
        r.idx = n_held[5:0];
        rects.push_back(r);
        n_held++;
        area = area + 38'(w) * 38'(h);
        if (w > widest) widest = w;
        if (last || n_held >= 64) pack_set();
    endfunction

    function void check_result(logic [71:0] data, logic placed, logic last);
        logic [71:0] ed;
        logic        ep;
        logic        el;
        if (exp_data.size() == 0) begin
            $error("unexpected result word %h", data);
            errors++;
            return;
        end
        ed = exp_data.pop_front();
        ep = exp_placed.pop_front();
        el = exp_last.pop_front();
        if (data[5:0] != ed[5:0]) begin
            $error("rect_index exp %0d got %0d", ed[5:0], data[5:0]); errors++;
        end
        if (data[21:6] != ed[21:6]) begin
            $error("pos_left exp %0d got %0d", ed[21:6], data[21:6]); errors++;
        end
        if (data[37:22] != ed[37:22]) begin
            $error("pos_bottom exp %0d got %0d", ed[37:22], data[37:22]); errors++;
        end
        if (data[53:38] != ed[53:38]) begin
            $error("total_width exp %0d got %0d", ed[53:38], data[53:38]); errors++;
        end
        if (data[69:54] != ed[69:54]) begin
            $error("total_height exp %0d got %0d", ed[69:54], data[69:54]); errors++;
        end
        if (placed != ep) begin
            $error("placed exp %0d got %0d", ep, placed); errors++;
        end
        if (last != el) begin
            $error("last_result exp %0d got %0d", el, last); errors++;
        end
    endfunction
endclass

module testbench;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // rect_width, rect_height
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // rect_index, pos_left, pos_bottom, totals
    logic        m_axis_tuser;   // placed
    logic        m_axis_tlast;

    pack_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int cycles;
    int n_sent;

    shelf_rectangle_packer DUT (.*);

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("shelf_rectangle_packer test failed");
            $finish;
        end
    end

    task automatic send_rect(logic [15:0] w, logic [15:0] h, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {h, w};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_rect(w, h, last);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.exp_data.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_dim(int mode);
        case (mode)
            0: return 16'($urandom_range(1, 64));
            1: return 16'($urandom_range(1, 1024));
            2: return 16'($urandom_range(1, 65535));
            default: return ($urandom_range(1) ? 16'hFFFF : 16'd1);
        endcase
    endfunction

    task automatic random_set();
        int n;
        int mode;
        int i;
        n = ($urandom_range(9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 12);
        mode = $urandom_range(3);
        for (i = 0; i < n; i++)
            send_rect(rand_dim(mode), rand_dim(mode),
                      (i == n - 1) && (n < 64 || $urandom_range(1)));
    endtask

    initial begin
        int ph;
        sb = new();
        cycles = 0;
        n_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, exact fits, oversize and unplaced
        send_rect(16'd1, 16'd1, 1'b1);
        send_rect(16'hFFFF, 16'hFFFF, 1'b1);
        send_rect(16'hFFFF, 16'd1, 1'b0);
        send_rect(16'd1, 16'hFFFF, 1'b0);
        send_rect(16'h5555, 16'hAAAA, 1'b1);
        send_rect(16'd10, 16'd10, 1'b0);
        send_rect(16'd10, 16'd10, 1'b0);
        send_rect(16'd10, 16'd5, 1'b0);
        send_rect(16'd20, 16'd5, 1'b1);
        send_rect(16'd4, 16'd3, 1'b0);
        send_rect(16'd4, 16'd3, 1'b0);
        send_rect(16'd2, 16'd3, 1'b0);
        send_rect(16'd3, 16'd7, 1'b1);
        send_rect(16'hAAAA, 16'h5555, 1'b0);
        send_rect(16'h8000, 16'h8000, 1'b1);
        drain();
        // store full without a last marker
        for (int i = 0; i < 64; i++)
            send_rect(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)), 1'b0);
        drain();

        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 70 : 0;
            recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 11 : 0;
            while (n_sent < 79 + 75 * (ph + 1)) begin
                random_set();
                if ($urandom_range(7) == 0) drain();
            end
        end
        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.exp_data.size() == 0)
            $display("shelf_rectangle_packer test passed");
        else
            $display("shelf_rectangle_packer test failed");
        $finish;
    end
endmodule
